FILE: rtl/core/assert_macros.svh
// Assertion macros used by the deframer parser (wfdc_parser).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is active.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/wfdc_pkg.sv
// Package: types, constants and status codes of the frame deframer.
`default_nettype none

package wfdc_pkg;

  localparam int MAX_FRAME_BYTES = 4096;
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t FLD_PROD = CNT_W'(4);
  localparam cnt_t FLD_DEV  = CNT_W'(8);
  localparam cnt_t FLD_FUNC = CNT_W'(10);
  localparam cnt_t FLD_LEN  = CNT_W'(12);
  localparam cnt_t HDR_CNT  = CNT_W'(16);
  localparam cnt_t MAX_CNT  = CNT_W'(MAX_FRAME_BYTES);

  localparam logic [32:0] MAX_TOTAL      = 33'(MAX_FRAME_BYTES);
  localparam logic [32:0] FRAME_OVERHEAD = 33'(20);
  localparam logic [32:0] SUM_BYTES      = 33'(4);

  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_BAD_SUM   = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] payload_word;
    logic [31:0] product_id;
    logic [15:0] device_id;
    logic [15:0] function_code;
    status_t     frame_status;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/wfdc_ifs.sv
// Handshake channel interfaces: byte input, result output, config write.
`default_nettype none

interface wfdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_buffer;

  modport source (output valid, output rx_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface wfdc_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] payload_word;
  logic [31:0] product_id;
  logic [15:0] device_id;
  logic [15:0] function_code;
  logic [2:0]  frame_status;

  modport source (output valid, output result_kind, output payload_word,
                  output product_id, output device_id, output function_code,
                  output frame_status, input ready);
  modport sink   (input valid, input result_kind, input payload_word,
                  input product_id, input device_id, input function_code,
                  input frame_status, output ready);
endinterface

interface wfdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/wfdc_in_reg.sv
// Input register stage: captures one byte request per cycle while it is empty or the next stage advances.
`default_nettype none

module wfdc_in_reg (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wfdc_pkg::in_item_t    in_item,
  input  wire                   adv,
  output logic                  s1_valid,
  output wfdc_pkg::in_item_t    s1_item
);

  logic               valid_r;
  logic               valid_nxt;
  wfdc_pkg::in_item_t item_r;

  assign in_ready = !valid_r || adv;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

`default_nettype wire

FILE: rtl/core/wfdc_parser.sv
// Frame parser: field assembly, payload word output, running checksum and end-of-buffer status.
`default_nettype none
`include "assert_macros.svh"

module wfdc_parser (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire  [31:0]           cfg_data,
  input  wire                   fire,
  input  wfdc_pkg::in_item_t    item,
  output logic                  res_valid,
  output wfdc_pkg::result_t     res
);

  logic [31:0]       magic_cfg_r;
  wfdc_pkg::cnt_t    cnt_r, cnt_upd, cnt_nxt;
  logic [31:0]       magic_r, magic_upd, magic_nxt;
  logic [31:0]       prod_r, prod_upd, prod_nxt;
  logic [15:0]       dev_r, dev_upd, dev_nxt;
  logic [15:0]       func_r, func_upd, func_nxt;
  logic [31:0]       len_r, len_upd, len_nxt;
  logic [31:0]       wa_r, wa_upd, wa_nxt;
  logic [31:0]       acc_r, acc_upd, acc_nxt;
  logic [31:0]       rsum_r, rsum_upd, rsum_nxt;

  logic [7:0]        b;
  logic              last;
  logic              take;
  logic              word_done;
  logic [31:0]       add_val;
  wfdc_pkg::cnt_t    off;
  logic [1:0]        sum_lane;
  logic [32:0]       total;
  wfdc_pkg::status_t status;
  logic              lane3_pay;

  assign b    = item.rx_byte;
  assign last = item.end_of_buffer;
  assign take = fire && (cnt_r < wfdc_pkg::MAX_CNT);
  assign off  = cnt_r - wfdc_pkg::HDR_CNT;
  assign sum_lane = cnt_r[1:0] - len_r[1:0];
  assign lane3_pay = (cnt_r[1:0] == 2'd3) && (cnt_r >= wfdc_pkg::HDR_CNT);

  always_comb begin
    cnt_upd   = cnt_r;
    magic_upd = magic_r;
    prod_upd  = prod_r;
    dev_upd   = dev_r;
    func_upd  = func_r;
    len_upd   = len_r;
    wa_upd    = wa_r;
    rsum_upd  = rsum_r;
    add_val   = '0;
    word_done = 1'b0;
    if (take) begin
      cnt_upd = cnt_r + 1'b1;
      if (cnt_r < wfdc_pkg::FLD_PROD) begin
        magic_upd[{cnt_r[1:0], 3'b000} +: 8] = b;
        add_val = 32'(b) << {cnt_r[1:0], 3'b000};
      end else if (cnt_r < wfdc_pkg::FLD_DEV) begin
        prod_upd[{cnt_r[1:0], 3'b000} +: 8] = b;
        add_val = 32'(b) << {cnt_r[1:0], 3'b000};
      end else if (cnt_r < wfdc_pkg::FLD_FUNC) begin
        dev_upd[{cnt_r[0], 3'b000} +: 8] = b;
        add_val = 32'(b) << {cnt_r[0], 3'b000};
      end else if (cnt_r < wfdc_pkg::FLD_LEN) begin
        func_upd[{cnt_r[0], 3'b000} +: 8] = b;
        add_val = 32'(b) << {cnt_r[0], 3'b000};
      end else if (cnt_r < wfdc_pkg::HDR_CNT) begin
        len_upd[{cnt_r[1:0], 3'b000} +: 8] = b;
      end else if (32'(off) < len_r) begin
        if (cnt_r[1:0] == 2'd0) begin
          wa_upd = {24'h000000, b};
        end else begin
          wa_upd[{cnt_r[1:0], 3'b000} +: 8] = b;
        end
        add_val   = 32'(b) << {cnt_r[1:0], 3'b000};
        word_done = (cnt_r[1:0] == 2'd3);
      end else if (33'(off) < ({1'b0, len_r} + wfdc_pkg::SUM_BYTES)) begin
        rsum_upd[{sum_lane, 3'b000} +: 8] = b;
      end
    end
  end

  // Header bytes land in distinct lanes, so the byte-wise sum equals the field sum.
  assign acc_upd = acc_r + add_val;
  assign total   = {1'b0, len_upd} + wfdc_pkg::FRAME_OVERHEAD;

  always_comb begin
    if (cnt_upd < wfdc_pkg::HDR_CNT) begin
      status = wfdc_pkg::ST_SHORT;
    end else if (magic_upd != magic_cfg_r) begin
      status = wfdc_pkg::ST_BAD_MAGIC;
    end else if ((len_upd[1:0] != 2'd0) || (total > 33'(cnt_upd)) ||
                 (total > wfdc_pkg::MAX_TOTAL)) begin
      status = wfdc_pkg::ST_BAD_LEN;
    end else if (rsum_upd != acc_upd) begin
      status = wfdc_pkg::ST_BAD_SUM;
    end else begin
      status = wfdc_pkg::ST_OK;
    end
  end

  always_comb begin
    res_valid = fire && (last || word_done);
    res       = '0;
    if (last) begin
      res.result_kind   = wfdc_pkg::KIND_STATUS;
      res.product_id    = prod_upd;
      res.device_id     = dev_upd;
      res.function_code = func_upd;
      res.frame_status  = status;
    end else begin
      res.result_kind   = wfdc_pkg::KIND_WORD;
      res.payload_word  = wa_upd;
    end
  end

  always_comb begin
    if (fire && last) begin
      cnt_nxt   = '0;
      magic_nxt = '0;
      prod_nxt  = '0;
      dev_nxt   = '0;
      func_nxt  = '0;
      len_nxt   = '0;
      wa_nxt    = '0;
      acc_nxt   = '0;
      rsum_nxt  = '0;
    end else begin
      cnt_nxt   = cnt_upd;
      magic_nxt = magic_upd;
      prod_nxt  = prod_upd;
      dev_nxt   = dev_upd;
      func_nxt  = func_upd;
      len_nxt   = len_upd;
      wa_nxt    = wa_upd;
      acc_nxt   = acc_upd;
      rsum_nxt  = rsum_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_cfg_r <= '0;
      cnt_r       <= '0;
      magic_r     <= '0;
      prod_r      <= '0;
      dev_r       <= '0;
      func_r      <= '0;
      len_r       <= '0;
      wa_r        <= '0;
      acc_r       <= '0;
      rsum_r      <= '0;
    end else begin
      if (cfg_we) begin
        magic_cfg_r <= cfg_data;
      end
      cnt_r   <= cnt_nxt;
      magic_r <= magic_nxt;
      prod_r  <= prod_nxt;
      dev_r   <= dev_nxt;
      func_r  <= func_nxt;
      len_r   <= len_nxt;
      wa_r    <= wa_nxt;
      acc_r   <= acc_nxt;
      rsum_r  <= rsum_nxt;
    end
  end

  `ASSERT_CLK(a_clear_after_status, clk, rst_n, (fire && last) |=> (cnt_r == '0), "no clear")
  `ASSERT_CLK(a_word_on_lane3, clk, rst_n, (res_valid && !last) |-> lane3_pay, "word off lane")
  `ASSERT_CLK(a_count_sat, clk, rst_n, cnt_r <= wfdc_pkg::MAX_CNT, "byte count past saturation")

endmodule

`default_nettype wire

FILE: rtl/core/wfdc_out_reg.sv
// Result register: holds one result until the sink takes it.
`default_nettype none

module wfdc_out_reg (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   res_valid,
  input  wfdc_pkg::result_t     res,
  input  wire                   out_ready,
  output logic                  adv,
  output logic                  out_valid,
  output wfdc_pkg::result_t     out_res
);

  logic              valid_r;
  logic              valid_nxt;
  wfdc_pkg::result_t res_r;

  assign adv       = !valid_r || out_ready;
  assign valid_nxt = adv ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

FILE: rtl/core/word_frame_deframer_checksum_top.sv
// A byte request accepted into the input register has its result, if it yields one, in the output
//   register at the next edge where that register can load.
// Throughput: one byte per cycle while the sink keeps out_ready high; set by the input register / result register pair.
// A stalled sink holds one pending result plus one byte in the input register.
// Reset (rst_n low, synchronous) clears all frame state and the configured magic (magic_cfg_r) to zero.
`default_nettype none

module word_frame_deframer_checksum_top (
  input  wire         clk,
  input  wire         rst_n,
  wfdc_in_if.sink     in_if,
  wfdc_out_if.source  out_if,
  wfdc_cfg_if.sink    cfg_if
);

  wfdc_pkg::in_item_t in_item;
  wfdc_pkg::in_item_t s1_item;
  wfdc_pkg::result_t  res;
  wfdc_pkg::result_t  out_res;
  logic               s1_valid;
  logic               adv;
  logic               fire;
  logic               res_valid;

  assign in_item.rx_byte       = in_if.rx_byte;
  assign in_item.end_of_buffer = in_if.end_of_buffer;
  assign cfg_if.ready          = 1'b1;
  assign fire                  = s1_valid && adv;

  wfdc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .in_item  (in_item),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  wfdc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_if.valid),
    .cfg_data  (cfg_if.data),
    .fire      (fire),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  wfdc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_if.ready),
    .adv       (adv),
    .out_valid (out_if.valid),
    .out_res   (out_res)
  );

  assign out_if.result_kind   = out_res.result_kind;
  assign out_if.payload_word  = out_res.payload_word;
  assign out_if.product_id    = out_res.product_id;
  assign out_if.device_id     = out_res.device_id;
  assign out_if.function_code = out_res.function_code;
  assign out_if.frame_status  = out_res.frame_status;

endmodule

`default_nettype wire

FILE: test/tb_word_frame_deframer_checksum_top.sv
// Testbench for the word frame deframer: random and directed byte buffers vs. a local predictor.
`timescale 1ns / 100ps

module tb_word_frame_deframer_checksum_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic clk;
  logic rst_n;

  wfdc_in_if  in_ch ();
  wfdc_out_if out_ch ();
  wfdc_cfg_if cfg_ch ();

  word_frame_deframer_checksum_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  wfdc_pkg::in_item_t byte_feed[$];
  wfdc_pkg::result_t  results_due[$];
  wfdc_pkg::in_item_t next_byte;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 mismatches;
  int                 quiet_cycles;
  bit                 pressure_go;
  logic               hold_on;
  logic [31:0]        cfg_magic;

  // predictor state
  logic [31:0]        pred_magic;
  wfdc_pkg::cnt_t     rx_cnt;
  logic [31:0]        seen_magic;
  logic [31:0]        prod_q;
  logic [15:0]        dev_q;
  logic [15:0]        func_q;
  logic [31:0]        len_q;
  logic [31:0]        word_q;
  logic [31:0]        sum_q;
  logic [31:0]        rsum_q;

  function automatic void clear_frame_state();
    rx_cnt     = '0;
    seen_magic = '0;
    prod_q     = '0;
    dev_q      = '0;
    func_q     = '0;
    len_q      = '0;
    word_q     = '0;
    sum_q      = '0;
    rsum_q     = '0;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, input logic eob);
    wfdc_pkg::cnt_t    c;
    logic [32:0]       off;
    logic [32:0]       total;
    logic [1:0]        lane;
    logic              word_done;
    logic [31:0]       csum;
    wfdc_pkg::status_t st;
    wfdc_pkg::result_t r;
    word_done = 1'b0;
    if (rx_cnt < wfdc_pkg::MAX_CNT) begin
      c = rx_cnt;
      rx_cnt = rx_cnt + 1'b1;
      if (c < wfdc_pkg::FLD_PROD) begin
        seen_magic[8*c[1:0] +: 8] = b;
      end else if (c < wfdc_pkg::FLD_DEV) begin
        prod_q[8*c[1:0] +: 8] = b;
      end else if (c < wfdc_pkg::FLD_FUNC) begin
        dev_q[8*c[0] +: 8] = b;
      end else if (c < wfdc_pkg::FLD_LEN) begin
        func_q[8*c[0] +: 8] = b;
      end else if (c < wfdc_pkg::HDR_CNT) begin
        len_q[8*c[1:0] +: 8] = b;
      end else begin
        off = 33'(c - wfdc_pkg::HDR_CNT);
        if (off < {1'b0, len_q}) begin
          lane = off[1:0];
          if (lane == 2'd0) begin
            word_q = {24'h0, b};
          end else begin
            word_q[8*lane +: 8] = b;
          end
          if (lane == 2'd3) begin
            sum_q = sum_q + word_q;
            word_done = 1'b1;
          end
        end else if (off < {1'b0, len_q} + wfdc_pkg::SUM_BYTES) begin
          lane = off[1:0] - len_q[1:0];
          rsum_q[8*lane +: 8] = b;
        end
      end
    end
    r = '0;
    if (eob) begin
      total = {1'b0, len_q} + wfdc_pkg::FRAME_OVERHEAD;
      csum = pred_magic + prod_q + 32'(dev_q) + 32'(func_q) + sum_q;
      if (rx_cnt < wfdc_pkg::HDR_CNT) begin
        st = wfdc_pkg::ST_SHORT;
      end else if (seen_magic != pred_magic) begin
        st = wfdc_pkg::ST_BAD_MAGIC;
      end else if (len_q[1:0] != 2'd0 || total > 33'(rx_cnt) ||
                   total > wfdc_pkg::MAX_TOTAL) begin
        st = wfdc_pkg::ST_BAD_LEN;
      end else if (rsum_q != csum) begin
        st = wfdc_pkg::ST_BAD_SUM;
      end else begin
        st = wfdc_pkg::ST_OK;
      end
      r.result_kind   = wfdc_pkg::KIND_STATUS;
      r.product_id    = prod_q;
      r.device_id     = dev_q;
      r.function_code = func_q;
      r.frame_status  = st;
      results_due = {results_due, r};
      clear_frame_state();
    end else if (word_done) begin
      r.result_kind  = wfdc_pkg::KIND_WORD;
      r.payload_word = word_q;
      r.frame_status = wfdc_pkg::ST_OK;
      results_due = {results_due, r};
    end
  endfunction

  task automatic check_result();
    wfdc_pkg::result_t want;
    if (results_due.size() == 0) begin
      $error("unexpected result: kind %0d word %h status %0d", out_ch.result_kind,
             out_ch.payload_word, out_ch.frame_status);
      mismatches++;
    end else begin
      want = results_due.pop_front();
      if (out_ch.result_kind !== want.result_kind) begin
        $error("result_kind expected %0d got %0d", want.result_kind, out_ch.result_kind);
        mismatches++;
      end
      if (out_ch.payload_word !== want.payload_word) begin
        $error("payload_word expected %h got %h", want.payload_word, out_ch.payload_word);
        mismatches++;
      end
      if (out_ch.product_id !== want.product_id) begin
        $error("product_id expected %h got %h", want.product_id, out_ch.product_id);
        mismatches++;
      end
      if (out_ch.device_id !== want.device_id) begin
        $error("device_id expected %h got %h", want.device_id, out_ch.device_id);
        mismatches++;
      end
      if (out_ch.function_code !== want.function_code) begin
        $error("function_code expected %h got %h", want.function_code, out_ch.function_code);
        mismatches++;
      end
      if (out_ch.frame_status !== want.frame_status) begin
        $error("frame_status expected %0d got %0d", want.frame_status, out_ch.frame_status);
        mismatches++;
      end
    end
  endtask

  // byte request driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        deframe_byte(in_ch.rx_byte, in_ch.end_of_buffer);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_feed.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_byte = byte_feed.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.rx_byte       <= next_byte.rx_byte;
          in_ch.end_of_buffer <= next_byte.end_of_buffer;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        check_result();
      end
      out_ch.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (cfg_ch.valid && cfg_ch.ready) begin
      pred_magic = cfg_ch.data;
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    hold_on = 1'b0;
    wait (pressure_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_word_frame_deframer_checksum_top NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [31:0] pattern_word(input fill_t fill);
    if (fill == FILL_ZERO) begin
      return 32'h0;
    end else if (fill == FILL_ONES) begin
      return 32'hFFFF_FFFF;
    end
    return $urandom;
  endfunction

  // header, body, checksum (over the register magic), trailing bytes; cut > 0 truncates
  task automatic queue_frame(input logic [31:0] hdr_magic, input logic [31:0] plen,
                             input int body, input logic [31:0] sum_flip, input int trail,
                             input int cut, input fill_t fill);
    logic [7:0]         fb[$];
    logic [31:0]        prod;
    logic [15:0]        dev;
    logic [15:0]        func;
    logic [31:0]        sum;
    logic [31:0]        w;
    logic [7:0]         b;
    wfdc_pkg::in_item_t it;
    int                 i;
    int                 n;
    prod = pattern_word(fill);
    dev  = 16'(pattern_word(fill));
    func = 16'(pattern_word(fill));
    sum  = cfg_magic + prod + 32'(dev) + 32'(func);
    w    = '0;
    for (i = 0; i < 4; i++) fb = {fb, hdr_magic[8*i +: 8]};
    for (i = 0; i < 4; i++) fb = {fb, prod[8*i +: 8]};
    for (i = 0; i < 2; i++) fb = {fb, dev[8*i +: 8]};
    for (i = 0; i < 2; i++) fb = {fb, func[8*i +: 8]};
    for (i = 0; i < 4; i++) fb = {fb, plen[8*i +: 8]};
    for (i = 0; i < body; i++) begin
      b = 8'(pattern_word(fill));
      fb = {fb, b};
      w[8*(i%4) +: 8] = b;
      if (i % 4 == 3) sum = sum + w;
    end
    sum = sum ^ sum_flip;
    for (i = 0; i < 4; i++) fb = {fb, sum[8*i +: 8]};
    for (i = 0; i < trail; i++) fb = {fb, 8'($urandom)};
    n = (cut > 0 && cut < fb.size()) ? cut : fb.size();
    for (i = 0; i < n; i++) begin
      it.rx_byte       = fb[i];
      it.end_of_buffer = (i == n - 1);
      byte_feed = {byte_feed, it};
    end
  endtask

  task automatic queue_noise(input int len);
    wfdc_pkg::in_item_t it;
    int                 i;
    for (i = 0; i < len; i++) begin
      it.rx_byte       = 8'($urandom);
      it.end_of_buffer = (i == len - 1);
      byte_feed = {byte_feed, it};
    end
  endtask

  task automatic queue_random_buffer();
    int          pick;
    int          plen4;
    int          trail;
    logic [31:0] flip;
    pick  = $urandom_range(99);
    plen4 = 4 * $urandom_range(0, 6);
    trail = ($urandom_range(3) == 0) ? $urandom_range(1, 5) : 0;
    flip  = 32'h1 << $urandom_range(31);
    if (pick < 55) begin
      queue_frame(cfg_magic, plen4, plen4, '0, trail, 0, FILL_RANDOM);
    end else if (pick < 65) begin
      queue_frame(cfg_magic, plen4, plen4, flip, trail, 0, FILL_RANDOM);
    end else if (pick < 73) begin
      queue_frame(cfg_magic ^ flip, plen4, plen4, '0, trail, 0, FILL_RANDOM);
    end else if (pick < 80) begin
      queue_frame(cfg_magic, plen4 + $urandom_range(1, 3), plen4 + 3, '0, trail, 0,
                  FILL_RANDOM);
    end else if (pick < 88) begin
      queue_frame(cfg_magic, plen4 + 4, plen4 + 4, '0, 0, $urandom_range(16, 23 + plen4),
                  FILL_RANDOM);
    end else if (pick < 94) begin
      queue_noise($urandom_range(1, 15));
    end else begin
      queue_noise($urandom_range(16, 40));
    end
  endtask

  task automatic settle();
    while (byte_feed.size() != 0 || in_ch.valid || results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_magic(input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cfg_magic = value;
  endtask

  task automatic run_phase(input logic [31:0] magic, input int send_pct, input int stall_pct,
                           input int nbytes, input bit pressure);
    settle();
    write_magic(magic);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    if (pressure) pressure_go = 1'b1;
    while (byte_feed.size() < nbytes) queue_random_buffer();
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.rx_byte       = '0;
    in_ch.end_of_buffer = 1'b0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = '0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    mismatches          = 0;
    quiet_cycles        = 0;
    pressure_go         = 1'b0;
    cfg_magic           = '0;
    pred_magic          = '0;
    clear_frame_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    settle();
    write_magic(32'h0);
    queue_frame(32'hFFFF_FFFF, 0, 0, '0, 0, 1, FILL_ONES);
    queue_frame(32'h0, 0, 0, '0, 0, 0, FILL_ZERO);
    queue_frame(32'h0, 4, 4, '0, 0, 0, FILL_ONES);
    queue_frame(32'h1, 8, 8, '0, 0, 0, FILL_RANDOM);
    queue_frame(32'h0, 5, 5, '0, 0, 0, FILL_RANDOM);
    queue_frame(32'h0, 8, 8, '0, 0, 24, FILL_RANDOM);
    queue_frame(32'h0, 12, 12, 32'h8000_0000, 0, 0, FILL_RANDOM);
    queue_frame(32'h0, 4, 4, '0, 3, 0, FILL_RANDOM);
    queue_frame(32'h0, 0, 0, '0, 0, 15, FILL_RANDOM);
    queue_frame(32'h0, 0, 0, '0, 0, 16, FILL_RANDOM);
    queue_frame(32'h0, 32'hFFFF_FFFC, 12, '0, 0, 0, FILL_RANDOM);

    run_phase(32'hFFFF_FFFF, 0, 0, 40, 1'b0);
    run_phase($urandom, 50, 0, 40, 1'b0);
    run_phase($urandom, 0, 50, 40, 1'b0);
    run_phase($urandom, 38, 38, 40, 1'b0);
    run_phase($urandom, 0, 0, 60, 1'b1);
    settle();

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb_word_frame_deframer_checksum_top OK");
    end else begin
      $display("tb_word_frame_deframer_checksum_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/wfdc_pkg.sv
rtl/core/wfdc_ifs.sv
rtl/core/wfdc_in_reg.sv
rtl/core/wfdc_parser.sv
rtl/core/wfdc_out_reg.sv
rtl/core/word_frame_deframer_checksum_top.sv
test/tb_word_frame_deframer_checksum_top.sv
